[design/hps_pkg.sv]
`default_nettype none
package hps_pkg;

   localparam int DEFAULT_MAX_STEPS = 16;
   localparam int STEP_BURST = 16;
   localparam int BURST_W = $clog2(STEP_BURST + 1);

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHANNEL_ENABLE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RUN_MS = 1'b1;
   localparam logic [15:0] MAX_RUN_MS_RESET = 16'd5000;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_LOAD  = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_FAULT = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type           mode;
      logic [31:0]        now_ms;
      logic [7:0]         step_hz;
      logic signed [15:0] step_ms;
      logic [7:0]         priority_req;
      logic               last_step;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] motor_hz;
      logic       last_result;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RUNCHK,
      S_LOOP,
      S_STEP,
      S_HALT,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic discard;
      logic fault;
      logic arm_run;
      logic halt;
      logic read;
      logic step;
      logic flush;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     usable;
      logic     playing;
      logic     loading;
      logic     run_expired;
      logic     step_due;
      logic     burst_left;
      logic     ptr_end;
      logic     emit_ok;
      logic     pend_valid;
   } status_type;

endpackage
`default_nettype wire

[design/hps_ctrl.sv]
`default_nettype none
module hps_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire hps_pkg::status_type status,
   output hps_pkg::cmd_type        cmd
);
   import hps_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.mode)
               MODE_LOAD:  state_in = S_IDLE;
               MODE_STOP:  state_in = S_HALT;
               MODE_FAULT: state_in = S_FLUSH;
               MODE_TICK: begin
                  if (status.usable && status.playing && !status.loading) begin
                     state_in = S_RUNCHK;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_RUNCHK: begin
            state_in = status.run_expired ? S_HALT : S_LOOP;
         end
         S_LOOP: begin
            if (status.step_due && status.burst_left) begin
               state_in = status.ptr_end ? S_HALT : S_STEP;
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_STEP: begin
            if (status.emit_ok) begin
               state_in = S_LOOP;
            end
         end
         S_HALT: begin
            if (status.emit_ok) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (!status.pend_valid || status.emit_ok) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         S_DISPATCH: begin
            unique case (status.mode)
               MODE_LOAD:  cmd.load = status.usable;
               MODE_STOP:  cmd.discard = 1'b1;
               MODE_FAULT: cmd.fault = 1'b1;
               MODE_TICK:  cmd.arm_run = status.usable && status.playing && !status.loading;
               default:    cmd = '0;
            endcase
         end
         S_RUNCHK: begin
            cmd = '0;
         end
         S_LOOP: begin
            cmd.read = status.step_due && status.burst_left && !status.ptr_end;
         end
         S_STEP: begin
            cmd.step = status.emit_ok;
         end
         S_HALT: begin
            cmd.halt = status.emit_ok;
         end
         S_FLUSH: begin
            cmd.flush = status.pend_valid && status.emit_ok;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

[design/hps_datapath.sv]
`default_nettype none
module hps_datapath #(
   parameter int MAX_STEPS = hps_pkg::DEFAULT_MAX_STEPS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hps_pkg::req_payload_type       req_payload,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output hps_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                           csr_wr_en,
   input  wire logic [hps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hps_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire hps_pkg::cmd_type               cmd,
   output hps_pkg::status_type                 status
);
   import hps_pkg::*;

   localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int CW = $clog2(MAX_STEPS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_STEPS);

   logic [7:0]  hz_mem  [MAX_STEPS];
   logic [15:0] dur_mem [MAX_STEPS];

   req_payload_type item_ff, item_in;
   logic            en_ff, en_in;
   logic [15:0]     max_run_ff, max_run_in;
   logic [CW-1:0]   total_ff, total_in;
   logic [CW-1:0]   ptr_ff, ptr_in;
   logic            playing_ff, playing_in;
   logic            loading_ff, loading_in;
   logic            rejected_ff, rejected_in;
   logic            fault_ff, fault_in;
   logic [7:0]      present_ff, present_in;
   logic [7:0]      prio_ff, prio_in;
   logic [31:0]     sdl_ff, sdl_in;
   logic [31:0]     rdl_ff, rdl_in;
   logic [BURST_W-1:0] starts_ff, starts_in;
   logic [7:0]      rd_hz_ff;
   logic [15:0]     rd_dur_ff;
   logic            pend_valid_ff, pend_valid_in;
   logic [7:0]      pend_hz_ff, pend_hz_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic            out_free;
   logic            usable;

   assign usable   = en_ff && !fault_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      logic          emit_req;
      logic [7:0]    emit_hz;
      logic          rej;
      logic [CW-1:0] tot;
      logic [15:0]   len;
      logic [31:0]   base;

      emit_req = 1'b0;
      emit_hz  = 8'd0;
      rej      = rejected_ff;
      tot      = total_ff;
      len      = 16'd0;
      base     = 32'd0;

      item_in       = item_ff;
      en_in         = en_ff;
      max_run_in    = max_run_ff;
      total_in      = total_ff;
      ptr_in        = ptr_ff;
      playing_in    = playing_ff;
      loading_in    = loading_ff;
      rejected_in   = rejected_ff;
      fault_in      = fault_ff;
      present_in    = present_ff;
      prio_in       = prio_ff;
      sdl_in        = sdl_ff;
      rdl_in        = rdl_ff;
      starts_in     = starts_ff;
      pend_valid_in = pend_valid_ff;
      pend_hz_in    = pend_hz_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHANNEL_ENABLE: en_in = csr_wdata[0];
            CSR_MAX_RUN_MS:     max_run_in = csr_wdata;
            default:            en_in = en_ff;
         endcase
      end

      if (cmd.capture) begin
         item_in = req_payload;
      end

      if (cmd.load) begin
         if (!loading_ff) begin
            if (playing_ff && (item_ff.priority_req < prio_ff)) begin
               rej = 1'b1;
            end else begin
               rej        = 1'b0;
               tot        = '0;
               ptr_in     = '0;
               sdl_in     = 32'd0;
               rdl_in     = 32'd0;
               prio_in    = item_ff.priority_req;
               playing_in = 1'b1;
            end
         end
         total_in = tot;
         if (!rej && (tot < MAX_COUNT)) begin
            mem_we    = 1'b1;
            mem_waddr = tot[AW-1:0];
            total_in  = tot + CW'(1);
         end
         rejected_in = rej;
         loading_in  = !item_ff.last_step;
      end

      if (cmd.discard && loading_ff) begin
         rejected_in = 1'b1;
      end

      // Halt and fault both drop the running pattern.
      if (cmd.halt || cmd.fault) begin
         if (cmd.fault || (en_ff && (present_ff != 8'd0))) begin
            emit_req = 1'b1;
            emit_hz  = 8'd0;
         end
         present_in = 8'd0;
         playing_in = 1'b0;
         total_in   = '0;
         ptr_in     = '0;
         sdl_in     = 32'd0;
         rdl_in     = 32'd0;
         prio_in    = 8'd0;
      end

      if (cmd.fault) begin
         fault_in = 1'b1;
         if (loading_ff) begin
            rejected_in = 1'b1;
         end
      end

      if (cmd.arm_run) begin
         starts_in = '0;
         if (rdl_ff == 32'd0) begin
            rdl_in = item_ff.now_ms + {16'd0, max_run_ff};
         end
      end

      if (cmd.step) begin
         if (rd_hz_ff != present_ff) begin
            present_in = rd_hz_ff;
            emit_req   = 1'b1;
            emit_hz    = rd_hz_ff;
         end
         len       = rd_dur_ff[15] ? 16'd0 : rd_dur_ff;
         base      = (sdl_ff == 32'd0) ? item_ff.now_ms : sdl_ff;
         sdl_in    = base + {16'd0, len};
         ptr_in    = ptr_ff + CW'(1);
         starts_in = starts_ff + BURST_W'(1);
      end

      // A new command pushes the held one out; the held one is last only at flush.
      if (emit_req) begin
         if (pend_valid_ff) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.motor_hz    = pend_hz_ff;
            rsp_data_in.last_result = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_hz_in    = emit_hz;
      end

      if (cmd.flush) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.motor_hz    = pend_hz_ff;
         rsp_data_in.last_result = 1'b1;
         pend_valid_in           = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hz_mem[mem_waddr]  <= item_ff.step_hz;
         dur_mem[mem_waddr] <= item_ff.step_ms;
      end
      if (cmd.read) begin
         rd_hz_ff  <= hz_mem[ptr_ff[AW-1:0]];
         rd_dur_ff <= dur_mem[ptr_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pend_hz_ff  <= pend_hz_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         en_ff         <= 1'b0;
         max_run_ff    <= MAX_RUN_MS_RESET;
         total_ff      <= '0;
         ptr_ff        <= '0;
         playing_ff    <= 1'b0;
         loading_ff    <= 1'b0;
         rejected_ff   <= 1'b0;
         fault_ff      <= 1'b0;
         present_ff    <= 8'd0;
         prio_ff       <= 8'd0;
         sdl_ff        <= 32'd0;
         rdl_ff        <= 32'd0;
         starts_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         en_ff         <= en_in;
         max_run_ff    <= max_run_in;
         total_ff      <= total_in;
         ptr_ff        <= ptr_in;
         playing_ff    <= playing_in;
         loading_ff    <= loading_in;
         rejected_ff   <= rejected_in;
         fault_ff      <= fault_in;
         present_ff    <= present_in;
         prio_ff       <= prio_in;
         sdl_ff        <= sdl_in;
         rdl_ff        <= rdl_in;
         starts_ff     <= starts_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      status             = '0;
      status.mode        = item_ff.mode;
      status.usable      = usable;
      status.playing     = playing_ff;
      status.loading     = loading_ff;
      status.run_expired = item_ff.now_ms >= rdl_ff;
      status.step_due    = item_ff.now_ms >= sdl_ff;
      status.burst_left  = starts_ff < BURST_W'(STEP_BURST);
      status.ptr_end     = ptr_ff >= total_ff;
      status.emit_ok     = !pend_valid_ff || out_free;
      status.pend_valid  = pend_valid_ff;
   end

endmodule
`default_nettype wire

[design/haptic_pattern_sequencer.sv]
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  mode, now_ms, step_hz, step_ms, priority_req, last_step
// rsp      out        rsp_valid/rsp_stall  motor_hz, last_result
// csr      in         csr_wr_en            csr_index, csr_wdata
//
// One item at a time. A load or an ignored tick passes through dispatch only, a fault also
// through flush and a stop through halt and flush. A tick that plays passes a run check, then
// a step store read and an update per step started, halt if it ends the pattern, and flush;
// waits come on top whenever the result register is stalled. Reset is synchronous; the step
// store is not cleared, only entries written by a load are read. Each result command is held
// until the next one or the end of the item, so that the final one of an item can be marked.
`default_nettype none
module haptic_pattern_sequencer #(
   parameter int MAX_STEPS = hps_pkg::DEFAULT_MAX_STEPS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire hps_pkg::req_payload_type        req_payload,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output hps_pkg::rsp_payload_type             rsp_payload,
   input  wire logic                            csr_wr_en,
   input  wire logic [hps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [hps_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hps_pkg::*;

   cmd_type    cmd;
   status_type status;

   hps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hps_datapath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .status      (status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while the previous one is still in work");

   a_flush_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |-> (status.pend_valid && status.emit_ok))
      else $error("final command flushed without a held command or free output");

   a_step_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.step || cmd.halt) |-> status.emit_ok)
      else $error("command issued while a held command cannot move out");

   a_single_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.load, cmd.discard, cmd.fault, cmd.arm_run,
                cmd.halt, cmd.read, cmd.step, cmd.flush}))
      else $error("more than one datapath command in one cycle");

endmodule
`default_nettype wire

[test/haptic_pattern_sequencer_checker.sv]
module haptic_pattern_sequencer_checker
   import hps_pkg::*;
#(
   parameter int DEPTH = DEFAULT_MAX_STEPS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  req_payload_type        req_payload,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rsp_payload_type        rsp_payload,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     failures,
   output int                     expected_left
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the sequencer state.
   logic [7:0]  tone_mem [DEPTH];
   logic [15:0] span_mem [DEPTH];
   int unsigned steps_loaded;
   int unsigned step_idx;
   bit          running;
   bit          filling;
   bit          discarding;
   bit          faulted;
   logic [7:0]  cur_hz;
   logic [7:0]  cur_prio;
   logic [31:0] step_due_at;
   logic [31:0] run_limit_at;
   bit          chan_en;
   logic [15:0] run_cap;

   logic [7:0]      hz_batch [$];
   rsp_payload_type motor_cmd_q [$];
   int              fail_total;

   task automatic drop_pattern();
      cur_hz = 8'd0;
      running = 1'b0;
      steps_loaded = 0;
      step_idx = 0;
      step_due_at = 32'd0;
      run_limit_at = 32'd0;
      cur_prio = 8'd0;
   endtask

   // Motor-off goes out only when the channel is enabled and the motor is running.
   task automatic motor_off();
      if (chan_en && cur_hz != 8'd0) begin
         hz_batch.push_back(8'd0);
      end
      drop_pattern();
   endtask

   always @(posedge clock) begin
      bit              usable;
      int              starts;
      logic [31:0]     span;
      rsp_payload_type cmd;
      rsp_payload_type want;
      if (reset) begin
         drop_pattern();
         filling = 1'b0;
         discarding = 1'b0;
         faulted = 1'b0;
         chan_en = 1'b0;
         run_cap = MAX_RUN_MS_RESET;
         motor_cmd_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHANNEL_ENABLE: chan_en = csr_wdata[0];
               CSR_MAX_RUN_MS:     run_cap = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            if (motor_cmd_q.size() == 0) begin
               $error("motor_hz: no command expected, actual %0d", rsp_payload.motor_hz);
               fail_total++;
            end else begin
               want = motor_cmd_q.pop_front();
               if (rsp_payload.motor_hz !== want.motor_hz) begin
                  $error("motor_hz: expected %0d, actual %0d",
                         want.motor_hz, rsp_payload.motor_hz);
                  fail_total++;
               end
               if (rsp_payload.last_result !== want.last_result) begin
                  $error("last_result: expected %0d, actual %0d",
                         want.last_result, rsp_payload.last_result);
                  fail_total++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            usable = chan_en && !faulted;
            hz_batch.delete();
            case (req_payload.mode)
               MODE_LOAD: begin
                  if (usable) begin
                     // The first item of a load decides by priority whether it takes over.
                     if (!filling) begin
                        if (running && req_payload.priority_req < cur_prio) begin
                           discarding = 1'b1;
                        end else begin
                           discarding = 1'b0;
                           steps_loaded = 0;
                           step_idx = 0;
                           step_due_at = 32'd0;
                           run_limit_at = 32'd0;
                           cur_prio = req_payload.priority_req;
                           running = 1'b1;
                        end
                     end
                     if (!discarding && steps_loaded < DEPTH) begin
                        tone_mem[steps_loaded] = req_payload.step_hz;
                        span_mem[steps_loaded] = req_payload.step_ms;
                        steps_loaded++;
                     end
                     filling = !req_payload.last_step;
                  end
               end
               MODE_STOP: begin
                  if (filling) discarding = 1'b1;
                  motor_off();
               end
               MODE_FAULT: begin
                  if (filling) discarding = 1'b1;
                  hz_batch.push_back(8'd0);
                  drop_pattern();
                  faulted = 1'b1;
               end
               default: begin
                  if (usable && running && !filling) begin
                     if (run_limit_at == 32'd0) begin
                        run_limit_at = req_payload.now_ms + {16'd0, run_cap};
                     end
                     if (req_payload.now_ms >= run_limit_at) begin
                        motor_off();
                     end else begin
                        starts = 0;
                        while (running && req_payload.now_ms >= step_due_at
                               && starts < STEP_BURST) begin
                           if (step_idx >= steps_loaded || step_idx >= DEPTH) begin
                              motor_off();
                              break;
                           end
                           if (tone_mem[step_idx] != cur_hz) begin
                              cur_hz = tone_mem[step_idx];
                              hz_batch.push_back(cur_hz);
                           end
                           span = span_mem[step_idx][15] ? 32'd0 : {16'd0, span_mem[step_idx]};
                           step_due_at = (step_due_at == 32'd0 ? req_payload.now_ms
                                                              : step_due_at) + span;
                           step_idx++;
                           starts++;
                        end
                     end
                  end
               end
            endcase
            for (int k = 0; k < hz_batch.size(); k++) begin
               cmd.motor_hz = hz_batch[k];
               cmd.last_result = (k == hz_batch.size() - 1);
               motor_cmd_q.push_back(cmd);
            end
         end
      end
      failures <= fail_total;
      expected_left <= motor_cmd_q.size();
   end

endmodule

[test/haptic_pattern_sequencer_tb.sv]
module haptic_pattern_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hps_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int          failures;
   int          expected_left;
   int          items_sent;
   bit          req_idle_on = 1'b1;
   bit          stall_on = 1'b1;
   logic [31:0] ms_now;

   haptic_pattern_sequencer uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   haptic_pattern_sequencer_checker cmd_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .failures      (failures),
      .expected_left (expected_left)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= stall_on && ($urandom_range(99) < 37);
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Called just after the clock rises; returns once the block has taken the item.
   task automatic send_item(input mode_type mode, input logic [31:0] now,
                            input logic [7:0] hz, input logic signed [15:0] ms,
                            input logic [7:0] prio, input logic last);
      req_payload_type item;
      item.mode = mode;
      item.now_ms = now;
      item.step_hz = hz;
      item.step_ms = ms;
      item.priority_req = prio;
      item.last_step = last;
      if (req_idle_on && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_plain(input mode_type mode, input logic [31:0] now);
      send_item(mode, now, 8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
   endtask

   task automatic load_step(input logic [7:0] hz, input logic signed [15:0] ms,
                            input logic [7:0] prio, input logic last);
      send_item(MODE_LOAD, $urandom, hz, ms, prio, last);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all commands, then give the block time to finish an item that sends none.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic run_random_phase(input int count);
      int                 first;
      int                 n_steps;
      int                 n_ticks;
      int                 r;
      logic [7:0]         hz;
      logic signed [15:0] ms;
      logic [7:0]         prio;
      first = items_sent;
      while (items_sent - first < count) begin
         if ($urandom_range(99) < 72) begin
            n_steps = ($urandom_range(9) == 0) ? $urandom_range(15, 18) : $urandom_range(1, 7);
            prio = 8'($urandom);
            hz = 8'($urandom);
            for (int i = 0; i < n_steps; i++) begin
               if ($urandom_range(99) < 65) hz = 8'($urandom);
               r = $urandom_range(99);
               if (r < 15) ms = {1'b1, 15'($urandom)};
               else if (r < 25) ms = 16'($urandom);
               else if (r < 40) ms = 16'sd0;
               else ms = 16'($urandom_range(1, 12));
               if ($urandom_range(99) < 5) send_plain(MODE_TICK, ms_now);
               if (i > 0 && $urandom_range(99) < 2) send_plain(MODE_STOP, $urandom);
               load_step(hz, ms, prio, i == n_steps - 1);
            end
            n_ticks = $urandom_range(1, n_steps + 4);
            for (int i = 0; i < n_ticks; i++) begin
               if ($urandom_range(99) < 8) ms_now += $urandom_range(40000);
               else ms_now += $urandom_range(8);
               if ($urandom_range(99) < 4) send_plain(MODE_STOP, $urandom);
               else send_plain(MODE_TICK, ms_now);
            end
         end else begin
            send_item(mode_type'($urandom_range(2)), $urandom_range(1) ? ms_now : $urandom,
                      8'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The channel comes out of reset disabled, so none of these may answer.
      load_step(8'd50, 16'sd5, 8'd3, 1'b1);
      send_plain(MODE_TICK, 32'd10);
      send_plain(MODE_STOP, $urandom);
      settle();
      write_reg(CSR_CHANNEL_ENABLE, 16'd1);

      // Seventeen zero-length steps overflow the store; a tick mid-load is ignored,
      // the next tick starts a full burst and the one after it ends the pattern.
      for (int i = 0; i < 17; i++) begin
         if (i == 6) send_plain(MODE_TICK, 32'd0);
         load_step((i % 2 == 0) ? 8'(255 - i) : 8'(i),
                   (i % 3 == 0) ? 16'sh8000 : ((i % 3 == 1) ? -16'sd1 : 16'sd0),
                   8'd10, i == 16);
      end
      send_plain(MODE_TICK, 32'd0);
      load_step(8'd77, 16'sd3, 8'd9, 1'b1);
      send_plain(MODE_TICK, 32'd0);
      // Equal priority takes over; a stop during the load discards the rest of it.
      load_step(8'd9, 16'sh7FFF, 8'd255, 1'b1);
      send_plain(MODE_TICK, 32'd1);
      load_step(8'd0, 16'sd1, 8'd255, 1'b0);
      send_plain(MODE_STOP, $urandom);
      load_step(8'd200, 16'sd2, 8'd0, 1'b1);
      send_plain(MODE_TICK, 32'd2);
      settle();

      ms_now = $urandom;
      run_random_phase(80);
      settle();
      write_reg(CSR_MAX_RUN_MS, 16'd1);
      run_random_phase(60);
      settle();

      // Time close to wrapping, and no idling on either side.
      write_reg(CSR_MAX_RUN_MS, 16'hFFFF);
      ms_now = 32'hFFFF_FF80 + $urandom_range(63);
      req_idle_on = 1'b0;
      stall_on <= 1'b0;
      run_random_phase(70);
      settle();
      req_idle_on = 1'b1;
      stall_on <= 1'b1;

      write_reg(CSR_MAX_RUN_MS, 16'($urandom_range(1, 65535)));
      ms_now = $urandom;
      run_random_phase(80);
      settle();
      write_reg(CSR_CHANNEL_ENABLE, 16'd0);
      run_random_phase(20);
      settle();
      write_reg(CSR_CHANNEL_ENABLE, 16'd1);
      write_reg(CSR_MAX_RUN_MS, MAX_RUN_MS_RESET);
      run_random_phase(100);
      settle();

      // A fault latches the channel off for the rest of the run, so it comes last.
      load_step(8'd33, 16'sd4, 8'd128, 1'b1);
      send_plain(MODE_TICK, 32'hFFFF_FFFF);
      load_step(8'd44, 16'sd5, 8'd1, 1'b1);
      send_plain(MODE_TICK, 32'd100);
      load_step(8'd55, 16'sd5, 8'd255, 1'b0);
      send_plain(MODE_FAULT, $urandom);
      load_step(8'd66, 16'sd5, 8'd255, 1'b1);
      send_plain(MODE_TICK, 32'd200);
      send_plain(MODE_STOP, $urandom);
      send_plain(MODE_FAULT, $urandom);
      settle();

      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
